>>> hw/rtl/first_fit_cell_allocator_macros.svh
// Assertion macros shared by the cell allocator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef FIRST_FIT_CELL_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_CELL_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked property, switched off while reset is high.
`define FFCA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds through reset.
`define FFCA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FFCA_ASSERT(label, clk, rst, prop, msg)
`define FFCA_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> hw/rtl/ffca_pkg.sv
// Shared types, step codes, micro-op codes and condition codes for the
// first-fit cell allocator. No dependencies.
package ffca_pkg;

   localparam int CELLS_DEF    = 1024;
   localparam int TAG_BITS_DEF = 16;

   localparam int WORD_W   = 16;
   localparam int SIZE_W   = 11;
   localparam int OFF_W    = 2;
   localparam int STATUS_W = 2;
   localparam int TAG_OUT_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int FIDX_W   = WORD_W + OFF_W;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_WORD    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_IN_USE = 2'd1;

   localparam logic [SIZE_W-1:0] CELLS_IN_USE_RST = 11'd1024;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

   // microprogram steps
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] S_CLR    = 4'd0;
   localparam logic [STEP_W-1:0] S_IDLE   = 4'd1;
   localparam logic [STEP_W-1:0] S_ACHK   = 4'd2;
   localparam logic [STEP_W-1:0] S_ASCAN  = 4'd3;
   localparam logic [STEP_W-1:0] S_ASTAMP = 4'd4;
   localparam logic [STEP_W-1:0] S_AOK    = 4'd5;
   localparam logic [STEP_W-1:0] S_RFAIL  = 4'd6;
   localparam logic [STEP_W-1:0] S_RRANGE = 4'd7;
   localparam logic [STEP_W-1:0] S_FCHK   = 4'd8;
   localparam logic [STEP_W-1:0] S_FTAG   = 4'd9;
   localparam logic [STEP_W-1:0] S_FWALK  = 4'd10;
   localparam logic [STEP_W-1:0] S_ROK    = 4'd11;

   // datapath micro-ops
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
   localparam logic [OP_W-1:0] OP_CLEAR     = 4'd1;
   localparam logic [OP_W-1:0] OP_IDLE      = 4'd2;
   localparam logic [OP_W-1:0] OP_SCAN      = 4'd3;
   localparam logic [OP_W-1:0] OP_STAMP     = 4'd4;
   localparam logic [OP_W-1:0] OP_RSP_ALLOC = 4'd5;
   localparam logic [OP_W-1:0] OP_RSP_FAIL  = 4'd6;
   localparam logic [OP_W-1:0] OP_RSP_RANGE = 4'd7;
   localparam logic [OP_W-1:0] OP_RSP_OK    = 4'd8;
   localparam logic [OP_W-1:0] OP_FIDX      = 4'd9;
   localparam logic [OP_W-1:0] OP_FTAG      = 4'd10;
   localparam logic [OP_W-1:0] OP_FWALK     = 4'd11;

   // jump conditions
   localparam int COND_W = 4;
   localparam logic [COND_W-1:0] C_NEVER       = 4'd0;
   localparam logic [COND_W-1:0] C_START_ALLOC = 4'd1;
   localparam logic [COND_W-1:0] C_START_FREE  = 4'd2;
   localparam logic [COND_W-1:0] C_CLR_LAST    = 4'd3;
   localparam logic [COND_W-1:0] C_BAD_SIZE    = 4'd4;
   localparam logic [COND_W-1:0] C_SCAN_HIT    = 4'd5;
   localparam logic [COND_W-1:0] C_SCAN_END    = 4'd6;
   localparam logic [COND_W-1:0] C_STAMP_LAST  = 4'd7;
   localparam logic [COND_W-1:0] C_FREE_BAD    = 4'd8;
   localparam logic [COND_W-1:0] C_TAG_ZERO    = 4'd9;
   localparam logic [COND_W-1:0] C_NO_MATCH    = 4'd10;
   localparam logic [COND_W-1:0] C_WALK_END    = 4'd11;

   typedef struct packed {
      logic              idle;
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond_a;
      logic [STEP_W-1:0] tgt_a;
      logic [COND_W-1:0] cond_b;
      logic [STEP_W-1:0] tgt_b;
      logic [STEP_W-1:0] tgt_f;
   } ucode_type;

   typedef struct packed {
      logic start_alloc;
      logic start_free;
      logic clr_last;
      logic bad_size;
      logic scan_hit;
      logic scan_end;
      logic stamp_last;
      logic free_bad;
      logic tag_zero;
      logic no_match;
      logic walk_end;
   } flags_type;

endpackage

>>> hw/rtl/first_fit_cell_allocator.sv
// First-fit byte-cell allocator with an owner-tag map.
// Command port in (start/busy), strobed result out, CSR write channel.
// Results: rsp_valid is high for exactly one cycle with block_word,
// block_offset, block_tag and status; the receiver cannot hold it off.
// An allocate checks the size, scans the cells up to the end of the first
// fitting run (at most the region size), stamps that run with the new tag
// and gives the result; a refused allocate gives its result after a full
// scan, or straight after the size check for a zero or oversized request.
// A free checks the address, reads the named cell's tag and clears cells
// of that tag until the walk stops on a cell of another tag or reaches
// the region end; it clears nothing when the named cell is already free
// and gives a range result when the address is outside the region. The
// tag memory is visited one cell per cycle.
// One command is in flight at a time; busy drops in the cycle the strobe
// shows, so the next command can be accepted then.
// After reset busy stays high while the tag memory is cleared, one cell per
// cycle. CSRs (index 0 base_word, index 1 cells_in_use) reset to 0 and
// 1024, are always ready, are written while idle by the user (not enforced).
// Depends on ffca_pkg, ffca_ucode_seq and ffca_datapath.
module first_fit_cell_allocator #(
   parameter int CELLS    = ffca_pkg::CELLS_DEF,
   parameter int TAG_BITS = ffca_pkg::TAG_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_func,
   input  logic [ffca_pkg::SIZE_W-1:0]       req_size,
   input  logic [ffca_pkg::WORD_W-1:0]       req_word_addr,
   input  logic [ffca_pkg::OFF_W-1:0]        req_byte_offset,
   output logic                              rsp_valid,
   output logic [ffca_pkg::WORD_W-1:0]       rsp_block_word,
   output logic [ffca_pkg::OFF_W-1:0]        rsp_block_offset,
   output logic [ffca_pkg::TAG_OUT_W-1:0]    rsp_block_tag,
   output logic [ffca_pkg::STATUS_W-1:0]     rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ffca_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ffca_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ffca_pkg::ucode_type cw;
   ffca_pkg::flags_type flags;

   assign busy      = ~cw.idle;
   assign csr_ready = 1'b1;

   ffca_ucode_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .cw    (cw)
   );

   ffca_datapath #(
      .CELLS    (CELLS),
      .TAG_BITS (TAG_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cw               (cw),
      .flags            (flags),
      .start            (start),
      .req_func         (req_func),
      .req_size         (req_size),
      .req_word_addr    (req_word_addr),
      .req_byte_offset  (req_byte_offset),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_block_word   (rsp_block_word),
      .rsp_block_offset (rsp_block_offset),
      .rsp_block_tag    (rsp_block_tag),
      .rsp_status       (rsp_status)
   );

endmodule

>>> hw/rtl/ffca_ucode_seq.sv
// Microcode sequencer: step counter, control store and two-way conditional jump.
// Depends on ffca_pkg and first_fit_cell_allocator_macros.svh.
`include "first_fit_cell_allocator_macros.svh"

module ffca_ucode_seq (
   input  logic                clock,
   input  logic                reset,
   input  ffca_pkg::flags_type flags,
   output ffca_pkg::ucode_type cw
);

   logic [ffca_pkg::STEP_W-1:0] pc_ff;
   logic [ffca_pkg::STEP_W-1:0] pc_in;
   logic                        jump_a;
   logic                        jump_b;

   function automatic ffca_pkg::ucode_type rom(input logic [ffca_pkg::STEP_W-1:0] step);
      ffca_pkg::ucode_type w;
      w = '{idle: 1'b0, op: ffca_pkg::OP_NOP,
            cond_a: ffca_pkg::C_NEVER, tgt_a: ffca_pkg::S_IDLE,
            cond_b: ffca_pkg::C_NEVER, tgt_b: ffca_pkg::S_IDLE,
            tgt_f: ffca_pkg::S_IDLE};
      unique case (step)
         ffca_pkg::S_CLR: begin
            w.op = ffca_pkg::OP_CLEAR;
            w.cond_a = ffca_pkg::C_CLR_LAST;  w.tgt_a = ffca_pkg::S_IDLE;
            w.tgt_f = ffca_pkg::S_CLR;
         end
         ffca_pkg::S_IDLE: begin
            w.idle = 1'b1;
            w.op = ffca_pkg::OP_IDLE;
            w.cond_a = ffca_pkg::C_START_ALLOC; w.tgt_a = ffca_pkg::S_ACHK;
            w.cond_b = ffca_pkg::C_START_FREE;  w.tgt_b = ffca_pkg::S_FCHK;
            w.tgt_f = ffca_pkg::S_IDLE;
         end
         ffca_pkg::S_ACHK: begin
            w.cond_a = ffca_pkg::C_BAD_SIZE; w.tgt_a = ffca_pkg::S_RFAIL;
            w.tgt_f = ffca_pkg::S_ASCAN;
         end
         ffca_pkg::S_ASCAN: begin
            w.op = ffca_pkg::OP_SCAN;
            w.cond_a = ffca_pkg::C_SCAN_HIT; w.tgt_a = ffca_pkg::S_ASTAMP;
            w.cond_b = ffca_pkg::C_SCAN_END; w.tgt_b = ffca_pkg::S_RFAIL;
            w.tgt_f = ffca_pkg::S_ASCAN;
         end
         ffca_pkg::S_ASTAMP: begin
            w.op = ffca_pkg::OP_STAMP;
            w.cond_a = ffca_pkg::C_STAMP_LAST; w.tgt_a = ffca_pkg::S_AOK;
            w.tgt_f = ffca_pkg::S_ASTAMP;
         end
         ffca_pkg::S_AOK:    w.op = ffca_pkg::OP_RSP_ALLOC;
         ffca_pkg::S_RFAIL:  w.op = ffca_pkg::OP_RSP_FAIL;
         ffca_pkg::S_RRANGE: w.op = ffca_pkg::OP_RSP_RANGE;
         ffca_pkg::S_FCHK: begin
            w.op = ffca_pkg::OP_FIDX;
            w.cond_a = ffca_pkg::C_FREE_BAD; w.tgt_a = ffca_pkg::S_RRANGE;
            w.tgt_f = ffca_pkg::S_FTAG;
         end
         ffca_pkg::S_FTAG: begin
            w.op = ffca_pkg::OP_FTAG;
            w.cond_a = ffca_pkg::C_TAG_ZERO; w.tgt_a = ffca_pkg::S_ROK;
            w.tgt_f = ffca_pkg::S_FWALK;
         end
         ffca_pkg::S_FWALK: begin
            w.op = ffca_pkg::OP_FWALK;
            w.cond_a = ffca_pkg::C_NO_MATCH; w.tgt_a = ffca_pkg::S_ROK;
            w.cond_b = ffca_pkg::C_WALK_END; w.tgt_b = ffca_pkg::S_ROK;
            w.tgt_f = ffca_pkg::S_FWALK;
         end
         ffca_pkg::S_ROK:    w.op = ffca_pkg::OP_RSP_OK;
         default:            w.tgt_f = ffca_pkg::S_IDLE;
      endcase
      return w;
   endfunction

   function automatic logic test(input logic [ffca_pkg::COND_W-1:0] c,
                                 input ffca_pkg::flags_type f);
      logic r;
      r = 1'b0;
      unique case (c)
         ffca_pkg::C_START_ALLOC: r = f.start_alloc;
         ffca_pkg::C_START_FREE:  r = f.start_free;
         ffca_pkg::C_CLR_LAST:    r = f.clr_last;
         ffca_pkg::C_BAD_SIZE:    r = f.bad_size;
         ffca_pkg::C_SCAN_HIT:    r = f.scan_hit;
         ffca_pkg::C_SCAN_END:    r = f.scan_end;
         ffca_pkg::C_STAMP_LAST:  r = f.stamp_last;
         ffca_pkg::C_FREE_BAD:    r = f.free_bad;
         ffca_pkg::C_TAG_ZERO:    r = f.tag_zero;
         ffca_pkg::C_NO_MATCH:    r = f.no_match;
         ffca_pkg::C_WALK_END:    r = f.walk_end;
         default:                 r = 1'b0;
      endcase
      return r;
   endfunction

   assign cw     = rom(pc_ff);
   assign jump_a = test(cw.cond_a, flags);
   assign jump_b = test(cw.cond_b, flags);

   always_comb begin
      if (jump_a) begin
         pc_in = cw.tgt_a;
      end else if (jump_b) begin
         pc_in = cw.tgt_b;
      end else begin
         pc_in = cw.tgt_f;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ffca_pkg::S_CLR;
      end else begin
         pc_ff <= pc_in;
      end
   end

   `FFCA_ASSERT_ALWAYS(a_reset_to_clear, clock, reset |=> pc_ff == ffca_pkg::S_CLR, "reset did not restart the clearing pass")
   `FFCA_ASSERT(a_accept_leaves_idle, clock, reset, (pc_ff == ffca_pkg::S_IDLE && (flags.start_alloc || flags.start_free)) |=> pc_ff != ffca_pkg::S_IDLE, "accepted transaction left the sequencer idle")

endmodule

>>> hw/rtl/ffca_datapath.sv
// Datapath: owner-tag memory, cell index, run counter, tag counter, CSRs
// and result registers. Depends on ffca_pkg and the macros header.
`include "first_fit_cell_allocator_macros.svh"

module ffca_datapath #(
   parameter int CELLS    = ffca_pkg::CELLS_DEF,
   parameter int TAG_BITS = ffca_pkg::TAG_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ffca_pkg::ucode_type               cw,
   output ffca_pkg::flags_type               flags,
   input  logic                              start,
   input  logic                              req_func,
   input  logic [ffca_pkg::SIZE_W-1:0]       req_size,
   input  logic [ffca_pkg::WORD_W-1:0]       req_word_addr,
   input  logic [ffca_pkg::OFF_W-1:0]        req_byte_offset,
   input  logic                              csr_valid,
   input  logic [ffca_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ffca_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                              rsp_valid,
   output logic [ffca_pkg::WORD_W-1:0]       rsp_block_word,
   output logic [ffca_pkg::OFF_W-1:0]        rsp_block_offset,
   output logic [ffca_pkg::TAG_OUT_W-1:0]    rsp_block_tag,
   output logic [ffca_pkg::STATUS_W-1:0]     rsp_status
);

   localparam int IDX_W = $clog2(CELLS);
   localparam int N_W   = IDX_W + 1;
   localparam int CMP_W = (N_W > ffca_pkg::SIZE_W) ? N_W : ffca_pkg::SIZE_W;

   logic [TAG_BITS-1:0] mem [CELLS];

   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    start_ff, start_in;
   logic [IDX_W-1:0]    end_ff, end_in;
   logic [CMP_W-1:0]    run_ff, run_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [TAG_BITS-1:0] next_tag_ff, next_tag_in;
   logic [TAG_BITS-1:0] rd_ff;
   logic [ffca_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [ffca_pkg::WORD_W-1:0] waddr_ff, waddr_in;
   logic [ffca_pkg::OFF_W-1:0]  boff_ff, boff_in;
   logic [ffca_pkg::WORD_W-1:0] base_ff, base_in;
   logic [ffca_pkg::SIZE_W-1:0] ciu_ff, ciu_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ffca_pkg::WORD_W-1:0]   rsp_word_ff, rsp_word_in;
   logic [ffca_pkg::OFF_W-1:0]    rsp_off_ff, rsp_off_in;
   logic [ffca_pkg::TAG_OUT_W-1:0] rsp_tag_ff, rsp_tag_in;
   logic [ffca_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                wr_en;
   logic [TAG_BITS-1:0] wr_data;
   logic                accept;
   logic [CMP_W-1:0]    ciu_mask;
   logic [CMP_W-1:0]    n_cmp;
   logic [CMP_W-1:0]    idx_cmp;
   logic                last_cell;
   logic                cell_free;
   logic [CMP_W-1:0]    run_next;
   logic [IDX_W-1:0]    start_cur;
   logic [ffca_pkg::WORD_W-1:0] diff;
   logic [ffca_pkg::FIDX_W-1:0] fidx;

   assign accept    = start & cw.idle;
   assign ciu_mask  = CMP_W'({ciu_ff[ffca_pkg::SIZE_W-1:2], 2'b00});
   assign n_cmp     = (ciu_mask > CMP_W'(CELLS)) ? CMP_W'(CELLS) : ciu_mask;
   assign idx_cmp   = CMP_W'(idx_ff);
   assign last_cell = idx_cmp == (n_cmp - CMP_W'(1));
   assign cell_free = rd_ff == '0;
   assign run_next  = run_ff + CMP_W'(1);
   assign start_cur = (run_ff == '0) ? idx_ff : start_ff;
   assign diff      = waddr_ff - base_ff;
   assign fidx      = {diff, boff_ff};

   always_comb begin
      flags.start_alloc = accept & ~req_func;
      flags.start_free  = accept & req_func;
      flags.clr_last    = idx_ff == IDX_W'(CELLS - 1);
      flags.bad_size    = (size_ff == '0) || (CMP_W'(size_ff) > n_cmp);
      flags.scan_hit    = cell_free && (run_next == CMP_W'(size_ff));
      flags.scan_end    = last_cell;
      flags.stamp_last  = idx_ff == end_ff;
      flags.free_bad    = (waddr_ff < base_ff) || (fidx >= ffca_pkg::FIDX_W'(n_cmp));
      flags.tag_zero    = cell_free;
      flags.no_match    = rd_ff != tag_ff;
      flags.walk_end    = last_cell;
   end

   always_comb begin
      idx_in        = idx_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      run_in        = run_ff;
      tag_in        = tag_ff;
      next_tag_in   = next_tag_ff;
      size_in       = size_ff;
      waddr_in      = waddr_ff;
      boff_in       = boff_ff;
      wr_en         = 1'b0;
      wr_data       = '0;
      rsp_valid_in  = 1'b0;
      rsp_word_in   = rsp_word_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_status_in = rsp_status_ff;
      unique case (cw.op) inside
         ffca_pkg::OP_CLEAR: begin
            wr_en  = 1'b1;
            idx_in = idx_ff + IDX_W'(1);
         end
         ffca_pkg::OP_IDLE: begin
            if (accept) begin
               size_in  = req_size;
               waddr_in = req_word_addr;
               boff_in  = req_byte_offset;
               idx_in   = '0;
               run_in   = '0;
            end
         end
         ffca_pkg::OP_SCAN: begin
            if (cell_free) begin
               run_in   = run_next;
               start_in = start_cur;
               if (flags.scan_hit) begin
                  idx_in = start_cur;
                  end_in = idx_ff;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end else begin
               run_in = '0;
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ffca_pkg::OP_STAMP: begin
            wr_en   = 1'b1;
            wr_data = next_tag_ff;
            idx_in  = idx_ff + IDX_W'(1);
         end
         ffca_pkg::OP_RSP_ALLOC: begin
            rsp_valid_in  = 1'b1;
            rsp_word_in   = base_ff + ffca_pkg::WORD_W'(start_ff >> 2);
            rsp_off_in    = start_ff[1:0];
            rsp_tag_in    = ffca_pkg::TAG_OUT_W'(next_tag_ff);
            rsp_status_in = ffca_pkg::ST_OK;
            next_tag_in   = (next_tag_ff == '1) ? TAG_BITS'(1) : next_tag_ff + TAG_BITS'(1);
         end
         ffca_pkg::OP_RSP_FAIL, ffca_pkg::OP_RSP_RANGE, ffca_pkg::OP_RSP_OK: begin
            rsp_valid_in  = 1'b1;
            rsp_word_in   = '0;
            rsp_off_in    = '0;
            rsp_tag_in    = '0;
            if (cw.op == ffca_pkg::OP_RSP_FAIL) begin
               rsp_status_in = ffca_pkg::ST_NO_SPACE;
            end else if (cw.op == ffca_pkg::OP_RSP_RANGE) begin
               rsp_status_in = ffca_pkg::ST_RANGE;
            end else begin
               rsp_status_in = ffca_pkg::ST_OK;
            end
         end
         ffca_pkg::OP_FIDX: idx_in = fidx[IDX_W-1:0];
         ffca_pkg::OP_FTAG: tag_in = rd_ff;
         ffca_pkg::OP_FWALK: begin
            if (!flags.no_match) begin
               wr_en  = 1'b1;
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      base_in = base_ff;
      ciu_in  = ciu_ff;
      if (csr_valid) begin
         case (csr_index)
            ffca_pkg::CSR_BASE_WORD:    base_in = csr_wdata;
            ffca_pkg::CSR_CELLS_IN_USE: ciu_in  = csr_wdata[ffca_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // tag store: one write, one registered read at the next index
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= wr_data;
      end
      rd_ff <= mem[idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         next_tag_ff  <= TAG_BITS'(1);
         base_ff      <= '0;
         ciu_ff       <= ffca_pkg::CELLS_IN_USE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         next_tag_ff  <= next_tag_in;
         base_ff      <= base_in;
         ciu_ff       <= ciu_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      end_ff        <= end_in;
      run_ff        <= run_in;
      tag_ff        <= tag_in;
      size_ff       <= size_in;
      waddr_ff      <= waddr_in;
      boff_ff       <= boff_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_block_word   = rsp_word_ff;
   assign rsp_block_offset = rsp_off_ff;
   assign rsp_block_tag    = rsp_tag_ff;
   assign rsp_status       = rsp_status_ff;

   `FFCA_ASSERT(a_rsp_single_cycle, clock, reset, rsp_valid_ff |=> !rsp_valid_ff, "result strobe held for more than one cycle")
   `FFCA_ASSERT(a_stamp_in_region, clock, reset, (cw.op == ffca_pkg::OP_STAMP) |-> (idx_cmp < n_cmp), "stamp outside the managed region")
   `FFCA_ASSERT(a_tag_never_zero, clock, reset, next_tag_ff != '0, "tag counter reached the free code")

endmodule

>>> tb/first_fit_cell_allocator_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_cell_allocator: a directed command table and
// random command phases over many region settings, checked by a local model and fixed results.
// Depends on ffca_pkg and the allocator RTL only.
module first_fit_cell_allocator_tb;

   localparam int     MAP_CELLS    = ffca_pkg::CELLS_DEF;
   localparam int     RANDOM_ITEMS = 480;
   localparam int     DRAIN_CYCLES = 2 * ffca_pkg::CELLS_DEF + 8;
   localparam longint LIMIT_CYCLES = 10_000_000;
   localparam logic   FUNC_ALLOC   = 1'b0;
   localparam logic   FUNC_FREE    = 1'b1;
   localparam logic [ffca_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam logic [ffca_pkg::TAG_OUT_W-1:0] TAG_LAST     = '1;

   typedef struct packed {
      logic                        op;
      logic [ffca_pkg::SIZE_W-1:0] count;
      logic [ffca_pkg::WORD_W-1:0] waddr;
      logic [ffca_pkg::OFF_W-1:0]  boff;
   } cmd_type;

   typedef struct packed {
      logic [ffca_pkg::WORD_W-1:0]    bword;
      logic [ffca_pkg::OFF_W-1:0]     boff;
      logic [ffca_pkg::TAG_OUT_W-1:0] btag;
      logic [ffca_pkg::STATUS_W-1:0]  status;
   } result_type;

   typedef struct {
      bit                              is_cfg;
      cmd_type                         cmd;
      logic [ffca_pkg::CSR_DATA_W-1:0] cfg_base;
      logic [ffca_pkg::CSR_DATA_W-1:0] cfg_cells;
      bit                              typed;
      result_type                      want;
   } step_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic                            req_func = 1'b0;
   logic [ffca_pkg::SIZE_W-1:0]     req_size = '0;
   logic [ffca_pkg::WORD_W-1:0]     req_word_addr = '0;
   logic [ffca_pkg::OFF_W-1:0]      req_byte_offset = '0;
   logic                            rsp_valid;
   logic [ffca_pkg::WORD_W-1:0]     rsp_block_word;
   logic [ffca_pkg::OFF_W-1:0]      rsp_block_offset;
   logic [ffca_pkg::TAG_OUT_W-1:0]  rsp_block_tag;
   logic [ffca_pkg::STATUS_W-1:0]   rsp_status;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [ffca_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [ffca_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   logic [ffca_pkg::TAG_OUT_W-1:0]  model_tags [MAP_CELLS];
   logic [ffca_pkg::TAG_OUT_W-1:0]  model_next_tag;
   logic [ffca_pkg::WORD_W-1:0]     model_base;
   logic [ffca_pkg::SIZE_W-1:0]     model_cells;

   result_type   pending_results [$];
   step_row_type directed_rows [$];
   result_type   want_q;
   int        burst_left = 0;
   int        mismatches = 0;
   int        results_seen = 0;
   int        n_directed = 0, n_random = 0, n_settings = 0;
   int        n_alloc_ok = 0, n_refused = 0, n_freed = 0, n_range = 0;
   longint    cycle_count = 0;

   first_fit_cell_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_size         (req_size),
      .req_word_addr    (req_word_addr),
      .req_byte_offset  (req_byte_offset),
      .rsp_valid        (rsp_valid),
      .rsp_block_word   (rsp_block_word),
      .rsp_block_offset (rsp_block_offset),
      .rsp_block_tag    (rsp_block_tag),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic cmd_type make_cmd(logic op, logic [ffca_pkg::SIZE_W-1:0] count,
                                        logic [ffca_pkg::WORD_W-1:0] waddr,
                                        logic [ffca_pkg::OFF_W-1:0] boff);
      cmd_type c;
      c.op = op;
      c.count = count;
      c.waddr = waddr;
      c.boff = boff;
      return c;
   endfunction

   function automatic result_type outcome(logic [ffca_pkg::WORD_W-1:0] bword,
                                          logic [ffca_pkg::OFF_W-1:0] boff,
                                          logic [ffca_pkg::TAG_OUT_W-1:0] btag,
                                          logic [ffca_pkg::STATUS_W-1:0] status);
      result_type r;
      r.bword = bword;
      r.boff = boff;
      r.btag = btag;
      r.status = status;
      return r;
   endfunction

   function automatic void row_cmd(cmd_type c, bit typed, result_type want);
      step_row_type row;
      row.is_cfg = 1'b0;
      row.cmd = c;
      row.cfg_base = '0;
      row.cfg_cells = '0;
      row.typed = typed;
      row.want = want;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic void row_cfg(logic [ffca_pkg::CSR_DATA_W-1:0] base,
                                   logic [ffca_pkg::CSR_DATA_W-1:0] cells);
      step_row_type row;
      row.is_cfg = 1'b1;
      row.cmd = '0;
      row.cfg_base = base;
      row.cfg_cells = cells;
      row.typed = 1'b0;
      row.want = '0;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic int region_size();
      int n;
      n = int'({model_cells[ffca_pkg::SIZE_W-1:2], 2'b00});
      if (n > MAP_CELLS) n = MAP_CELLS;
      return n;
   endfunction

   // Allocator state update for one accepted transaction; returns the result it should give.
   function automatic result_type allocator_predict(cmd_type c);
      result_type                     r;
      int                             n, run, first, i, idx;
      bit                             found;
      logic [ffca_pkg::TAG_OUT_W-1:0] tag;
      r = '0;
      n = region_size();
      if (c.op == FUNC_ALLOC) begin
         r.status = ffca_pkg::ST_NO_SPACE;
         found = 1'b0;
         if (c.count != 0 && int'(c.count) <= n) begin
            run = 0;
            first = 0;
            for (i = 0; i < n && !found; i++) begin
               if (model_tags[i] == '0) begin
                  if (run == 0) first = i;
                  run++;
                  if (run == int'(c.count)) found = 1'b1;
               end else begin
                  run = 0;
               end
            end
         end
         if (found) begin
            for (i = first; i < first + int'(c.count); i++) model_tags[i] = model_next_tag;
            r.bword = model_base + ffca_pkg::WORD_W'(first >> 2);
            r.boff = ffca_pkg::OFF_W'(first);
            r.btag = model_next_tag;
            r.status = ffca_pkg::ST_OK;
            model_next_tag = (model_next_tag == TAG_LAST) ? ffca_pkg::TAG_OUT_W'(1) :
                             model_next_tag + ffca_pkg::TAG_OUT_W'(1);
            n_alloc_ok++;
         end else begin
            n_refused++;
         end
      end else begin
         idx = (int'(c.waddr) - int'(model_base)) * 4 + int'(c.boff);
         if (c.waddr < model_base || idx >= n) begin
            r.status = ffca_pkg::ST_RANGE;
            n_range++;
         end else begin
            tag = model_tags[idx];
            if (tag != '0) begin
               for (i = idx; i < n && model_tags[i] == tag; i++) model_tags[i] = '0;
            end
            r.status = ffca_pkg::ST_OK;
            n_freed++;
         end
      end
      return r;
   endfunction

   // Mostly well-formed: allocations of modest size and frees aimed at live block starts.
   function automatic cmd_type pick_command();
      cmd_type c;
      int      n, r, idx;
      n = region_size();
      r = $urandom_range(0, 99);
      c.op = FUNC_ALLOC;
      c.count = ffca_pkg::SIZE_W'($urandom_range(0, 2047));
      c.waddr = ffca_pkg::WORD_W'($urandom);
      c.boff = ffca_pkg::OFF_W'($urandom);
      if (r < 55) begin
         if (r < 3) c.count = '0;
         else if (r < 7) c.count = ffca_pkg::SIZE_W'($urandom_range(n, 2047));
         else if (r < 12) c.count = ffca_pkg::SIZE_W'($urandom_range(1, (n > 0) ? n : 1));
         else c.count = ffca_pkg::SIZE_W'($urandom_range(1, (n > 8) ? n / 4 : 2));
      end else begin
         c.op = FUNC_FREE;
         if (r < 85 && n > 0) begin
            idx = $urandom_range(0, n - 1);
            if ($urandom_range(0, 3) != 0) begin
               while (idx > 0 && model_tags[idx] != '0 && model_tags[idx - 1] == model_tags[idx])
                  idx--;
            end
            c.waddr = model_base + ffca_pkg::WORD_W'(idx >> 2);
            c.boff = ffca_pkg::OFF_W'(idx);
         end else if (r < 92) begin
            c.waddr = model_base - ffca_pkg::WORD_W'($urandom_range(1, 4));
         end
      end
      return c;
   endfunction

   task automatic report_mismatch(input string field, input logic [15:0] want,
                                  input logic [15:0] got);
      mismatches++;
      $display("mismatch at result %0d: %s expected %0h got %0h", results_seen, field,
               want, got);
   endtask

   task automatic send_command(input cmd_type c, input bit gaps, input bit typed,
                               input result_type want, output result_type predicted);
      if (gaps && burst_left <= 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      start = 1'b1;
      req_func = c.op;
      req_size = c.count;
      req_word_addr = c.waddr;
      req_byte_offset = c.boff;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = allocator_predict(c);
      pending_results.insert(pending_results.size(), typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      start = 1'b0;
      while (pending_results.size() != 0 || busy !== 1'b0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [ffca_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ffca_pkg::CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == ffca_pkg::CSR_BASE_WORD) model_base = data;
      else if (idx == ffca_pkg::CSR_CELLS_IN_USE) model_cells = data[ffca_pkg::SIZE_W-1:0];
      @(negedge clock);
   endtask

   task automatic apply_setting(input logic [ffca_pkg::CSR_DATA_W-1:0] base,
                                input logic [ffca_pkg::CSR_DATA_W-1:0] cells,
                                input bit poke_unmapped);
      wait_idle();
      if (poke_unmapped) csr_write(CSR_UNMAPPED, ffca_pkg::CSR_DATA_W'($urandom));
      csr_write(ffca_pkg::CSR_BASE_WORD, base);
      csr_write(ffca_pkg::CSR_CELLS_IN_USE, cells);
      csr_valid = 1'b0;
      n_settings++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("result with no transaction outstanding, status", '0,
                            16'(rsp_status));
         end else begin
            want_q = pending_results.pop_front();
            if (rsp_block_word !== want_q.bword)
               report_mismatch("block_word", want_q.bword, rsp_block_word);
            if (rsp_block_offset !== want_q.boff)
               report_mismatch("block_offset", 16'(want_q.boff), 16'(rsp_block_offset));
            if (rsp_block_tag !== want_q.btag)
               report_mismatch("block_tag", want_q.btag, rsp_block_tag);
            if (rsp_status !== want_q.status)
               report_mismatch("status", 16'(want_q.status), 16'(rsp_status));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      result_type                      predicted;
      int                              phase_len;
      bit                              gaps;
      int                              i;
      logic [ffca_pkg::CSR_DATA_W-1:0] base_v, cells_v;

      for (i = 0; i < MAP_CELLS; i++) model_tags[i] = '0;
      model_next_tag = ffca_pkg::TAG_OUT_W'(1);
      model_base = '0;
      model_cells = ffca_pkg::CELLS_IN_USE_RST;

      // reset settings: base 0, full region
      row_cmd(make_cmd(FUNC_ALLOC, 11'd0, 16'd0, 2'd0), 1'b1,
              outcome(16'd0, 2'd0, 16'd0, ffca_pkg::ST_NO_SPACE));
      row_cmd(make_cmd(FUNC_ALLOC, 11'd2047, 16'hFFFF, 2'd3), 1'b1,
              outcome(16'd0, 2'd0, 16'd0, ffca_pkg::ST_NO_SPACE));
      row_cmd(make_cmd(FUNC_ALLOC, 11'd1, 16'd0, 2'd0), 1'b1,
              outcome(16'd0, 2'd0, 16'd1, ffca_pkg::ST_OK));
      row_cmd(make_cmd(FUNC_ALLOC, 11'd3, 16'd0, 2'd0), 1'b1,
              outcome(16'd0, 2'd1, 16'd2, ffca_pkg::ST_OK));
      row_cmd(make_cmd(FUNC_ALLOC, 11'd1021, 16'd0, 2'd0), 1'b0, '0);
      row_cmd(make_cmd(FUNC_ALLOC, 11'd1020, 16'd0, 2'd0), 1'b0, '0);
      row_cmd(make_cmd(FUNC_FREE, 11'd0, 16'd0, 2'd2), 1'b0, '0);
      row_cmd(make_cmd(FUNC_ALLOC, 11'd2, 16'd0, 2'd0), 1'b0, '0);
      row_cmd(make_cmd(FUNC_FREE, 11'd0, 16'h0100, 2'd0), 1'b1,
              outcome(16'd0, 2'd0, 16'd0, ffca_pkg::ST_RANGE));
      row_cmd(make_cmd(FUNC_FREE, 11'h7FF, 16'hFFFF, 2'd3), 1'b1,
              outcome(16'd0, 2'd0, 16'd0, ffca_pkg::ST_RANGE));
      row_cmd(make_cmd(FUNC_FREE, 11'd0, 16'd1, 2'd0), 1'b0, '0);
      row_cmd(make_cmd(FUNC_FREE, 11'd0, 16'd1, 2'd0), 1'b1,
              outcome(16'd0, 2'd0, 16'd0, ffca_pkg::ST_OK));
      row_cmd(make_cmd(FUNC_ALLOC, 11'd1024, 16'd0, 2'd0), 1'b0, '0);
      // top base, oversized cell count: block addresses wrap past 0xFFFF
      row_cfg(16'hFFFF, 16'hFFFF);
      row_cmd(make_cmd(FUNC_FREE, 11'd0, 16'd0, 2'd0), 1'b1,
              outcome(16'd0, 2'd0, 16'd0, ffca_pkg::ST_RANGE));
      row_cmd(make_cmd(FUNC_FREE, 11'd0, 16'hFFFF, 2'd0), 1'b0, '0);
      row_cmd(make_cmd(FUNC_ALLOC, 11'd8, 16'd0, 2'd0), 1'b0, '0);
      row_cfg(16'd0, 16'd6);
      row_cmd(make_cmd(FUNC_ALLOC, 11'd1, 16'd0, 2'd0), 1'b0, '0);
      row_cmd(make_cmd(FUNC_ALLOC, 11'd4, 16'd0, 2'd0), 1'b0, '0);
      // free of a block that runs past the region end
      row_cfg(16'd0, 16'd8);
      row_cmd(make_cmd(FUNC_FREE, 11'd0, 16'd1, 2'd0), 1'b0, '0);
      // empty region
      row_cfg(16'h8000, 16'd0);
      row_cmd(make_cmd(FUNC_ALLOC, 11'd1, 16'd0, 2'd0), 1'b1,
              outcome(16'd0, 2'd0, 16'd0, ffca_pkg::ST_NO_SPACE));
      row_cmd(make_cmd(FUNC_FREE, 11'd0, 16'h8000, 2'd0), 1'b1,
              outcome(16'd0, 2'd0, 16'd0, ffca_pkg::ST_RANGE));
      row_cfg(16'd0, 16'd1024);
      row_cmd(make_cmd(FUNC_ALLOC, 11'd6, 16'd0, 2'd0), 1'b0, '0);
      row_cmd(make_cmd(FUNC_FREE, 11'd0, 16'd2, 2'd0), 1'b0, '0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].is_cfg) begin
            apply_setting(directed_rows[k].cfg_base, directed_rows[k].cfg_cells, 1'b0);
         end else begin
            send_command(directed_rows[k].cmd, 1'b1, directed_rows[k].typed,
                         directed_rows[k].want, predicted);
            n_directed++;
         end
      end

      while (n_random < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: cells_v = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd1024;
            1: cells_v = ffca_pkg::CSR_DATA_W'($urandom_range(0, 7));
            default: cells_v = ffca_pkg::CSR_DATA_W'($urandom_range(4, 96));
         endcase
         case ($urandom_range(0, 4))
            0: base_v = 16'd0;
            1: base_v = 16'hFFFF;
            2: base_v = 16'hFFFF - ffca_pkg::CSR_DATA_W'($urandom_range(0, 15));
            default: base_v = ffca_pkg::CSR_DATA_W'($urandom);
         endcase
         apply_setting(base_v, cells_v, $urandom_range(0, 3) == 0);
         phase_len = (cells_v >= 16'd1024) ? $urandom_range(15, 25) : $urandom_range(30, 60);
         if (phase_len > RANDOM_ITEMS - n_random) phase_len = RANDOM_ITEMS - n_random;
         gaps = $urandom_range(0, 4) != 0;
         repeat (phase_len) begin
            send_command(pick_command(), gaps, 1'b0, '0, predicted);
            n_random++;
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d directed and %0d random transactions over %0d settings",
               n_directed, n_random, n_settings);
      $display("summary: %0d blocks allocated, %0d refused, %0d frees, %0d outside region",
               n_alloc_ok, n_refused, n_freed, n_range);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
